[rtl/core/kvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value table
// Widths, command codes and the cell-to-cell link type.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int Depth     = 16;
	localparam int KeyWidth  = 16;
	localparam int DataWidth = 32;
	localparam int PosWidth  = 4;
	localparam int CntWidth  = 5;
	localparam int IdxWidth  = 4;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_FIND   = 3'd2,
		CMD_READ   = 3'd3,
		CMD_COUNT  = 3'd4,
		CMD_ALLOC  = 3'd5
	} cmd_t;

	// Operation applied by every cell at once
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_WRITE,
		OP_SHIFT,
		OP_SWAP_EVEN,
		OP_SWAP_ODD
	} cell_op_t;

	// Control from the sequencer to all cells
	typedef struct packed {
		cell_op_t              op;
		logic [IdxWidth-1:0]   idx;
		logic [KeyWidth-1:0]   key;
		logic [DataWidth-1:0]  data;
	} cell_ctl_t;

	// Entry held by one cell
	typedef struct packed {
		logic [KeyWidth-1:0]  key;
		logic [DataWidth-1:0] data;
	} entry_t;

endpackage

[rtl/core/kvt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_cell: one table entry
// Holds a key/data pair; writes, takes its upper neighbor on a remove shift,
// and exchanges with a neighbor during sort passes.
// ----------------------------------------------------------------------------
module kvt_cell
	import kvt_pkg::*;
(
	input  logic                clk,
	input  logic [IdxWidth-1:0] my_idx,
	input  logic                is_last,
	input  logic [CntWidth-1:0] live,
	input  cell_ctl_t           ctl,
	input  entry_t              lower,
	input  entry_t              upper,
	output entry_t              ent
);

	entry_t ent_q;
	logic   pair_even, low_member, hi_ok, lo_ok;

	// My partner under the current pass parity: lower member when parity matches
	assign low_member = (my_idx[0] == (ctl.op == OP_SWAP_ODD));
	assign hi_ok      = !is_last && ({1'b0, my_idx} + 5'd1 < live);
	assign lo_ok      = (my_idx != '0) && ({1'b0, my_idx} < live);
	assign pair_even  = (ctl.op == OP_SWAP_EVEN) || (ctl.op == OP_SWAP_ODD);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_WRITE: begin
				if (ctl.idx == my_idx) begin
					ent_q.key  <= ctl.key;
					ent_q.data <= ctl.data;
				end
			end
			OP_SHIFT: begin
				if (my_idx >= ctl.idx && !is_last) ent_q <= upper;
			end
			OP_SWAP_EVEN, OP_SWAP_ODD: begin
				if (pair_even && low_member) begin
					if (hi_ok && ent_q.key > upper.key) ent_q <= upper;
				end else if (pair_even) begin
					if (lo_ok && lower.key > ent_q.key) ent_q <= lower;
				end
			end
			default: ;
		endcase
	end

	assign ent = ent_q;

endmodule

[rtl/core/key_value_table_with_id_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_with_id_allocator_core: ordered key/data table
// Sequencer plus a chain of sixteen entry cells.
// ----------------------------------------------------------------------------
// One request at a time. Insert, count and read pass through the done state to
// the response register. Find and remove add a scan of the chain at one cell per
// cycle; remove closes the gap in the same cycle that finds the key. Allocate
// runs 16 odd-even exchange passes over the cell chain, then, if there is room,
// scans for the lowest unused key and adds it as an entry. The result waits in
// an output register until taken.
// s_tdata: command[2:0], key[18:3], payload[50:19], position[54:51], pad to 56.
// m_tdata: ok[0], key_out[16:1], data_out[48:17], count[53:49], pad to 56.
module key_value_table_with_id_allocator_core
	import kvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // command, key, payload, position
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // ok, key_out, data_out, count
);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_SORT, ST_FREE, ST_DONE} state_t;

	state_t               state_q;
	logic [2:0]           cmd_q;
	logic [KeyWidth-1:0]  key_q, cand_q;
	logic [DataWidth-1:0] pay_q;
	logic [IdxWidth-1:0]  idx_q;
	logic [CntWidth-1:0]  live_q;
	logic [CntWidth-1:0]  pass_q;
	cell_ctl_t            ctl;
	entry_t               ents [Depth];
	logic                 ok_q;
	logic [KeyWidth-1:0]  kout_q;
	logic [DataWidth-1:0] dout_q;
	entry_t               cur;
	logic                 in_range;
	logic                 rd_hit;
	logic                 has_room;

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign cur      = ents[idx_q];
	assign in_range = {1'b0, idx_q} < live_q;
	assign rd_hit   = {1'b0, s_tdata[54:51]} < live_q;
	assign has_room = live_q < CntWidth'(Depth);

	// Cell chain
	for (genvar g = 0; g < Depth; g++) begin : g_cell
		kvt_cell u_cell (
			.clk    (clk),
			.my_idx (IdxWidth'(g)),
			.is_last(g == Depth - 1),
			.live   (live_q),
			.ctl    (ctl),
			.lower  (ents[(g == 0) ? 0 : g - 1]),
			.upper  (ents[(g == Depth - 1) ? g : g + 1]),
			.ent    (ents[g])
		);
	end

	// Cell control from the sequencer state
	always_comb begin
		ctl.op   = OP_HOLD;
		ctl.idx  = idx_q;
		ctl.key  = key_q;
		ctl.data = pay_q;
		if (state_q == ST_IDLE && s_tvalid && s_tready &&
		    s_tdata[2:0] == CMD_INSERT && has_room) begin
			ctl.op  = OP_WRITE;
			ctl.idx = live_q[IdxWidth-1:0];
			ctl.key = s_tdata[18:3];
			ctl.data = s_tdata[50:19];
		end else if (state_q == ST_SCAN && cmd_q == CMD_REMOVE && in_range &&
		             cur.key == key_q) begin
			ctl.op = OP_SHIFT;
		end else if (state_q == ST_SORT) begin
			ctl.op = pass_q[0] ? OP_SWAP_ODD : OP_SWAP_EVEN;
		end else if (state_q == ST_FREE && !in_range) begin
			ctl.op  = OP_WRITE;
			ctl.idx = live_q[IdxWidth-1:0];
			ctl.key = cand_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			live_q   <= '0;
			m_tvalid <= 1'b0;
			idx_q    <= '0;
			pass_q   <= '0;
			cmd_q    <= '0;
			key_q    <= '0;
			pay_q    <= '0;
			cand_q   <= '0;
			ok_q     <= 1'b0;
			kout_q   <= '0;
			dout_q   <= '0;
		end else begin
			// Response register: set when done, cleared when taken
			if (state_q == ST_DONE) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						cmd_q  <= s_tdata[2:0];
						key_q  <= s_tdata[18:3];
						pay_q  <= s_tdata[50:19];
						idx_q  <= '0;
						pass_q <= '0;
						cand_q <= '0;
						kout_q <= '0;
						unique case (s_tdata[2:0])
							CMD_INSERT: begin
								state_q <= ST_DONE;
								ok_q    <= has_room;
								dout_q  <= '0;
								if (has_room) live_q <= live_q + 1'b1;
							end
							CMD_REMOVE, CMD_FIND: begin
								state_q <= ST_SCAN;
								ok_q    <= 1'b0;
								dout_q  <= '0;
							end
							CMD_READ: begin
								state_q <= ST_DONE;
								ok_q    <= rd_hit;
								dout_q  <= rd_hit ? ents[s_tdata[54:51]].data : '0;
							end
							CMD_COUNT: begin
								state_q <= ST_DONE;
								ok_q    <= 1'b1;
								dout_q  <= '0;
							end
							CMD_ALLOC: begin
								state_q <= ST_SORT;
								ok_q    <= 1'b0;
								dout_q  <= '0;
							end
							default: begin
								state_q <= ST_DONE;
								ok_q    <= 1'b0;
								dout_q  <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!in_range) begin
						state_q <= ST_DONE;
					end else if (cur.key == key_q) begin
						ok_q <= 1'b1;
						if (cmd_q == CMD_FIND) dout_q <= cur.data;
						else live_q <= live_q - 1'b1;
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == IdxWidth'(Depth - 1)) state_q <= ST_DONE;
					end
				end
				ST_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == CntWidth'(Depth - 1)) begin
						state_q <= has_room ? ST_FREE : ST_DONE;
					end
				end
				ST_FREE: begin
					if (!in_range) begin
						ok_q    <= 1'b1;
						kout_q  <= cand_q;
						live_q  <= live_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						if (cur.key == cand_q) cand_q <= cand_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {2'b00, live_q, dout_q, kout_q, ok_q};

endmodule
